[hw/rtl/dld_pkg.sv]
package dld_pkg;

  // pool size and derived widths
  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int FUNC_W   = 3;
  localparam int STAT_W   = 2;

  // operation codes carried on the input transaction
  localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DELETE     = 3'd4;
  localparam logic [FUNC_W-1:0] FN_CLEAR      = 3'd5;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

  // commands broadcast along the row of cells
  localparam int COP_W = 3;
  localparam logic [COP_W-1:0] COP_HOLD   = 3'd0;
  localparam logic [COP_W-1:0] COP_SHL    = 3'd1; // take right neighbour (pop front)
  localparam logic [COP_W-1:0] COP_SHR    = 3'd2; // take left neighbour (push front)
  localparam logic [COP_W-1:0] COP_APPEND = 3'd3; // first empty cell takes data
  localparam logic [COP_W-1:0] COP_DROP   = 3'd4; // last valid cell empties
  localparam logic [COP_W-1:0] COP_CLEAR  = 3'd5;
  localparam logic [COP_W-1:0] COP_SCAN   = 3'd6; // token cell compacts if take

  typedef struct packed {
    logic [COP_W-1:0] op;
    logic             take;
    logic [VAL_W-1:0] data;
  } cell_cmd_t;

endpackage

[hw/rtl/dld_cell.sv]
module dld_cell
  import dld_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cell_cmd_t        cmd,
  input  logic             sel,
  input  logic [VAL_W-1:0] left_value,
  input  logic             left_valid,
  input  logic [VAL_W-1:0] right_value,
  input  logic             right_valid,
  output logic [VAL_W-1:0] value,
  output logic             valid,
  output logic             match
);

  // entry compare against the broadcast key
  assign match = valid && (value == cmd.data);

  // occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (cmd.op)
        COP_SHL:    valid <= right_valid;
        COP_SHR:    valid <= left_valid;
        COP_APPEND: valid <= valid | left_valid;
        COP_DROP:   valid <= right_valid;
        COP_CLEAR:  valid <= 1'b0;
        COP_SCAN: begin
          if (sel && cmd.take) valid <= right_valid;
        end
        default:    valid <= valid;
      endcase
    end
  end

  // stored entry, no reset needed
  always_ff @(posedge clk) begin
    case (cmd.op)
      COP_SHL: value <= right_value;
      COP_SHR: value <= left_value;
      COP_APPEND: begin
        if (!valid && left_valid) value <= cmd.data;
      end
      COP_SCAN: begin
        if (sel && cmd.take) value <= right_value;
      end
      default: value <= value;
    endcase
  end

endmodule

[hw/rtl/dld_chain.sv]
module dld_chain
  import dld_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  cell_cmd_t           cmd,
  input  logic [IDX_W-1:0]    scan_idx,
  output logic [VAL_W-1:0]    front_value,
  output logic [VAL_W-1:0]    back_value,
  output logic [CAPACITY-1:0] match
);

  logic [VAL_W-1:0]    cell_value [CAPACITY];
  logic [CAPACITY-1:0] cell_valid;
  logic [CAPACITY:0]   valid_ext;

  assign valid_ext = {1'b0, cell_valid};

  // row of cells, head of the list in cell 0
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VAL_W-1:0] lv;
    logic             lvld;
    logic [VAL_W-1:0] rv;
    logic             rvld;

    if (i == 0) begin : g_first
      assign lv   = cmd.data;
      assign lvld = 1'b1;
    end else begin : g_mid
      assign lv   = cell_value[i-1];
      assign lvld = cell_valid[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign rv   = '0;
      assign rvld = 1'b0;
    end else begin : g_inner
      assign rv   = cell_value[i+1];
      assign rvld = cell_valid[i+1];
    end

    dld_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .sel         (scan_idx == IDX_W'(i)),
      .left_value  (lv),
      .left_valid  (lvld),
      .right_value (rv),
      .right_valid (rvld),
      .value       (cell_value[i]),
      .valid       (cell_valid[i]),
      .match       (match[i])
    );
  end

  // head is cell 0; zero when empty
  assign front_value = cell_valid[0] ? cell_value[0] : '0;

  // tail is the one valid cell whose right neighbour is empty
  always_comb begin
    back_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (valid_ext[i] && !valid_ext[i+1]) back_value = back_value | cell_value[i];
    end
  end

endmodule

[hw/rtl/doubly_linked_list_deque_top.sv]
// Deque held in a row of CAPACITY cells, head in cell 0, one transaction at a time.
// Push, pop and clear: the row changes on acceptance; the result is registered in the
// report state. Delete by value: a token walks one cell per cycle up to the last entry,
// then the result is registered likewise. A new item is taken only after that.
// A result not yet taken holds the block in its report state. Synchronous active-high
// reset empties all cells and control state but the key; no clearing pass is needed.
module doubly_linked_list_deque_top
  import dld_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic [7:0]  s_tuser,   // [2:0] func, rest zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [31:0] front_value, [63:32] back_value, [68:64] count
  output logic [7:0]  m_tuser    // [1:0] status, rest zero
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_REPORT = 2'd2;

  logic [1:0]          state;
  logic [1:0]          state_next;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic [STAT_W-1:0]   status;
  logic [STAT_W-1:0]   status_next;
  logic [IDX_W-1:0]    scan_idx;
  logic [IDX_W-1:0]    scan_idx_next;
  logic                found;
  logic                found_next;
  logic [VAL_W-1:0]    key;
  logic [VAL_W-1:0]    key_next;

  cell_cmd_t           cmd;
  logic [VAL_W-1:0]    front_value;
  logic [VAL_W-1:0]    back_value;
  logic [CAPACITY-1:0] match;
  logic                found_now;
  logic                scan_last;
  logic                out_free;
  logic [FUNC_W-1:0]   func;
  logic                accept;

  logic [STAT_W-1:0]   out_status;
  logic [VAL_W-1:0]    out_front;
  logic [VAL_W-1:0]    out_back;
  logic [CNT_W-1:0]    out_count;

  assign func      = s_tuser[FUNC_W-1:0];
  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign found_now = found || match[scan_idx];
  assign scan_last = (CNT_W'(scan_idx) == (count - CNT_W'(1)));

  dld_chain u_chain (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .scan_idx    (scan_idx),
    .front_value (front_value),
    .back_value  (back_value),
    .match       (match)
  );

  // sequencer: decode the operation, drive the row, walk for delete
  always_comb begin
    state_next    = state;
    count_next    = count;
    status_next   = status;
    scan_idx_next = scan_idx;
    found_next    = found;
    key_next      = key;
    cmd.op        = COP_HOLD;
    cmd.take      = 1'b0;
    cmd.data      = (state == S_IDLE) ? s_tdata : key;

    case (state)
      S_IDLE: begin
        if (accept) begin
          status_next = ST_OK;
          state_next  = S_REPORT;
          case (func)
            FN_PUSH_FRONT, FN_PUSH_BACK: begin
              if (count == CNT_W'(CAPACITY)) begin
                status_next = ST_FULL;
              end else begin
                cmd.op     = (func == FN_PUSH_FRONT) ? COP_SHR : COP_APPEND;
                count_next = count + CNT_W'(1);
              end
            end
            FN_POP_FRONT, FN_POP_BACK: begin
              if (count == '0) begin
                status_next = ST_EMPTY;
              end else begin
                cmd.op     = (func == FN_POP_FRONT) ? COP_SHL : COP_DROP;
                count_next = count - CNT_W'(1);
              end
            end
            FN_DELETE: begin
              if (count == '0) begin
                status_next = ST_EMPTY;
              end else begin
                key_next      = s_tdata;
                scan_idx_next = '0;
                found_next    = 1'b0;
                state_next    = S_SCAN;
              end
            end
            FN_CLEAR: begin
              cmd.op     = COP_CLEAR;
              count_next = '0;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        // token cell pulls its right neighbour in once the first hit is seen
        cmd.op   = COP_SCAN;
        cmd.take = found_now;
        if (scan_last) begin
          if (found_now) begin
            count_next  = count - CNT_W'(1);
            status_next = ST_OK;
          end else begin
            status_next = ST_NOTFOUND;
          end
          state_next = S_REPORT;
        end else begin
          scan_idx_next = scan_idx + IDX_W'(1);
          found_next    = found_now;
        end
      end
      S_REPORT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      status   <= ST_OK;
      scan_idx <= '0;
      found    <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      status   <= status_next;
      scan_idx <= scan_idx_next;
      found    <= found_next;
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
  end

  // output register: holds a result until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_REPORT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_REPORT && out_free) begin
      out_status <= status;
      out_front  <= front_value;
      out_back   <= back_value;
      out_count  <= count;
    end
  end

  assign m_tdata = {{(72 - 2 * VAL_W - CNT_W){1'b0}}, out_count, out_back, out_front};
  assign m_tuser = {{(8 - STAT_W){1'b0}}, out_status};

endmodule
